// ===== design/quadrature_direction_relay_macros.svh =====
// Assertion helpers for the quadrature direction relay.
`ifndef QUADRATURE_DIRECTION_RELAY_MACROS_SVH
`define QUADRATURE_DIRECTION_RELAY_MACROS_SVH

`ifndef SYNTHESIS
// Clocked on clk_i, off while rst_ni is low.
`define QDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Clocked on clk_i, checked during reset too.
`define QDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define QDR_ASSERT(lbl, prop, msg)
`define QDR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/qdr_pkg.sv =====
`default_nettype none

package qdr_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_PIN     = 2'd1,
    REQ_ACK     = 2'd2,
    REQ_RESTART = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    DIR_UNKNOWN = 2'd0,
    DIR_LEFT    = 2'd1,
    DIR_RIGHT   = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    MODE_STARTUP  = 2'd0,
    MODE_IDLE     = 2'd1,
    MODE_PRINTING = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_STARTUP_THRESHOLD = 2'd0,
    CFG_LIMIT_PULSE_TICKS = 2'd1,
    CFG_PRINTING_ENABLE   = 2'd2
  } cfg_idx_e;

  localparam int unsigned CNT_OUT_W = 16;
  localparam int unsigned NUM_CNT   = 5;
  localparam int unsigned CNT_LEFT   = 0;
  localparam int unsigned CNT_RIGHT  = 1;
  localparam int unsigned CNT_ERR    = 2;
  localparam int unsigned CNT_BOUNCE = 3;
  localparam int unsigned CNT_ACK    = 4;

  localparam logic [7:0] STARTUP_THRESHOLD_RST = 8'd50;
  localparam logic [7:0] LIMIT_PULSE_RST       = 8'd5;

  localparam logic [4:0] PHASE_NONE = 5'h1f;
  // serial refresh due every tenth heartbeat value
  localparam logic [3:0] SER_LAST = 4'd9;

  typedef struct packed {
    logic [7:0] startup_threshold;
    logic [7:0] limit_pulse_ticks;
    logic       printing_enable;
  } cfg_t;

  typedef struct packed {
    logic                 out_a;
    logic                 out_b;
    logic                 limit_drive;
    logic                 led;
    logic                 serial_request;
    dir_e                 direction;
    mode_e                mode;
    logic [CNT_OUT_W-1:0] left_count;
    logic [CNT_OUT_W-1:0] right_count;
    logic [CNT_OUT_W-1:0] error_count;
    logic [CNT_OUT_W-1:0] bounce_count;
    logic [CNT_OUT_W-1:0] ack_count;
  } result_t;

  // Gray step decode; no step from a previous value above 3.
  function automatic dir_e decode_step(logic [3:0] prev, logic [3:0] cur, dir_e keep);
    logic [3:0] left_of;
    logic [3:0] right_of;
    left_of  = 4'd0;
    right_of = 4'd0;
    case (prev[1:0])
      2'd0: begin left_of = 4'd2; right_of = 4'd1; end
      2'd1: begin left_of = 4'd0; right_of = 4'd3; end
      2'd2: begin left_of = 4'd3; right_of = 4'd0; end
      2'd3: begin left_of = 4'd1; right_of = 4'd2; end
      default: begin left_of = 4'd0; right_of = 4'd0; end
    endcase
    if (prev[3:2] != 2'd0) begin
      return keep;
    end else if (cur == left_of) begin
      return DIR_LEFT;
    end else if (cur == right_of) begin
      return DIR_RIGHT;
    end
    return keep;
  endfunction

  // Forward commutation 0,1,3,2; first step latches the pin value.
  function automatic logic [4:0] next_phase(logic [4:0] last, logic [3:0] pins);
    logic [4:0] ph;
    ph = PHASE_NONE;
    if (last == PHASE_NONE) begin
      ph = {1'b0, pins};
    end else if (last[4:2] == 3'd0) begin
      case (last[1:0])
        2'd0:    ph = 5'd1;
        2'd1:    ph = 5'd3;
        2'd2:    ph = 5'd0;
        2'd3:    ph = 5'd2;
        default: ph = PHASE_NONE;
      endcase
    end
    return ph;
  endfunction

endpackage

`default_nettype wire

// ===== design/qdr_cfg_regs.sv =====
`default_nettype none

module qdr_cfg_regs (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  output qdr_pkg::cfg_t   cfg_o
);

  qdr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (qdr_pkg::cfg_idx_e'(cfg_index_i))
        qdr_pkg::CFG_STARTUP_THRESHOLD: cfg_d.startup_threshold = cfg_data_i;
        qdr_pkg::CFG_LIMIT_PULSE_TICKS: cfg_d.limit_pulse_ticks = cfg_data_i;
        qdr_pkg::CFG_PRINTING_ENABLE:   cfg_d.printing_enable   = cfg_data_i[0];
        default: cfg_d = cfg_q;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_threshold <= qdr_pkg::STARTUP_THRESHOLD_RST;
      cfg_q.limit_pulse_ticks <= qdr_pkg::LIMIT_PULSE_RST;
      cfg_q.printing_enable   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/qdr_core.sv =====
`default_nettype none
`include "quadrature_direction_relay_macros.svh"

module qdr_core #(
  parameter int unsigned COUNT_WIDTH     = 16,
  parameter int unsigned HEARTBEAT_LIMIT = 100
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire qdr_pkg::req_e  req_i,
  input  wire logic [3:0]     pins_i,
  input  wire qdr_pkg::cfg_t  cfg_i,
  output qdr_pkg::result_t    res_o
);

  localparam int unsigned HbW = $clog2(HEARTBEAT_LIMIT + 2);
  localparam logic [HbW-1:0] HbLimit = HbW'(HEARTBEAT_LIMIT);
  localparam int unsigned OutW = qdr_pkg::CNT_OUT_W;

  logic [3:0]             last_pins_q, last_pins_d;
  qdr_pkg::dir_e          dir_q, dir_d;
  logic                   idle_q, idle_d;
  logic [7:0]             steps_q, steps_d;
  logic [7:0]             pulse_q, pulse_d;
  logic                   limit_q, limit_d;
  logic [HbW-1:0]         hb_q, hb_d;
  logic [3:0]             ser_q, ser_d;     // heartbeat value mod 10
  logic                   led_q, led_d;
  logic [4:0]             phase_q, phase_d;
  logic [1:0]             drive_q, drive_d;
  logic [COUNT_WIDTH-1:0] cnt_q [qdr_pkg::NUM_CNT];
  logic [COUNT_WIDTH-1:0] cnt_d [qdr_pkg::NUM_CNT];
  logic [OutW-1:0]        cnt_out [qdr_pkg::NUM_CNT];

  logic                   changed;
  logic                   serial;
  qdr_pkg::dir_e          dec_dir;
  logic [4:0]             ph;

  assign changed = (pins_i != last_pins_q);
  assign dec_dir = qdr_pkg::decode_step(last_pins_q, pins_i, dir_q);
  assign ph      = qdr_pkg::next_phase(phase_q, pins_i);

  always_comb begin
    last_pins_d = last_pins_q;
    dir_d       = dir_q;
    idle_d      = idle_q;
    steps_d     = steps_q;
    pulse_d     = pulse_q;
    limit_d     = limit_q;
    hb_d        = hb_q;
    ser_d       = ser_q;
    led_d       = led_q;
    phase_d     = phase_q;
    drive_d     = drive_q;
    cnt_d       = cnt_q;
    serial      = 1'b0;

    case (req_i)
      qdr_pkg::REQ_TICK: begin
        if (pulse_q != 8'd0) begin
          pulse_d = pulse_q - 8'd1;
        end else begin
          limit_d = 1'b0;
        end
        if (hb_q > HbLimit) begin
          hb_d  = '0;
          ser_d = 4'd0;
          led_d = ~led_q;
        end else begin
          hb_d  = hb_q + HbW'(1);
          ser_d = (ser_q == qdr_pkg::SER_LAST) ? 4'd0 : ser_q + 4'd1;
        end
        serial = (ser_d == 4'd0);
      end
      qdr_pkg::REQ_PIN: begin
        if (changed) begin
          dir_d = dec_dir;
          if (dec_dir == qdr_pkg::DIR_UNKNOWN) begin
            cnt_d[qdr_pkg::CNT_ERR] = cnt_q[qdr_pkg::CNT_ERR] + COUNT_WIDTH'(1);
          end else begin
            if (dec_dir == qdr_pkg::DIR_RIGHT) begin
              cnt_d[qdr_pkg::CNT_RIGHT] = cnt_q[qdr_pkg::CNT_RIGHT] + COUNT_WIDTH'(1);
            end else begin
              cnt_d[qdr_pkg::CNT_LEFT] = cnt_q[qdr_pkg::CNT_LEFT] + COUNT_WIDTH'(1);
            end
            if (!idle_q) begin
              steps_d = steps_q + 8'd1;
              if (steps_d >= cfg_i.startup_threshold) begin
                idle_d  = 1'b1;
                limit_d = 1'b1;
                pulse_d = cfg_i.limit_pulse_ticks;
              end
            end
          end
          if (idle_d && cfg_i.printing_enable) begin
            phase_d = ph;
            drive_d = ~ph[1:0];
          end
        end else begin
          cnt_d[qdr_pkg::CNT_BOUNCE] = cnt_q[qdr_pkg::CNT_BOUNCE] + COUNT_WIDTH'(1);
        end
        last_pins_d = pins_i;
      end
      qdr_pkg::REQ_ACK: begin
        cnt_d[qdr_pkg::CNT_ACK] = cnt_q[qdr_pkg::CNT_ACK] + COUNT_WIDTH'(1);
      end
      qdr_pkg::REQ_RESTART: begin
        steps_d = 8'd0;
        idle_d  = 1'b0;
        dir_d   = qdr_pkg::DIR_UNKNOWN;
        cnt_d[qdr_pkg::CNT_LEFT]  = '0;
        cnt_d[qdr_pkg::CNT_RIGHT] = '0;
        cnt_d[qdr_pkg::CNT_ERR]   = '0;
      end
      default: serial = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= 4'd0;
      dir_q       <= qdr_pkg::DIR_UNKNOWN;
      idle_q      <= 1'b0;
      steps_q     <= 8'd0;
      pulse_q     <= 8'd0;
      limit_q     <= 1'b0;
      hb_q        <= '0;
      ser_q       <= 4'd0;
      led_q       <= 1'b0;
      phase_q     <= qdr_pkg::PHASE_NONE;
      drive_q     <= 2'd0;
      for (int i = 0; i < qdr_pkg::NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (fire_i) begin
      last_pins_q <= last_pins_d;
      dir_q       <= dir_d;
      idle_q      <= idle_d;
      steps_q     <= steps_d;
      pulse_q     <= pulse_d;
      limit_q     <= limit_d;
      hb_q        <= hb_d;
      ser_q       <= ser_d;
      led_q       <= led_d;
      phase_q     <= phase_d;
      drive_q     <= drive_d;
      cnt_q       <= cnt_d;
    end
  end

  // counters leave at a fixed 16 bits
  for (genvar g = 0; g < qdr_pkg::NUM_CNT; g++) begin : g_cnt_out
    if (COUNT_WIDTH >= OutW) begin : g_trunc
      assign cnt_out[g] = cnt_d[g][OutW-1:0];
    end else begin : g_ext
      assign cnt_out[g] = {{(OutW - COUNT_WIDTH){1'b0}}, cnt_d[g]};
    end
  end

  always_comb begin
    res_o.out_a          = drive_d[1];
    res_o.out_b          = drive_d[0];
    res_o.limit_drive    = limit_d;
    res_o.led            = led_d;
    res_o.serial_request = serial;
    res_o.direction      = dir_d;
    if (!idle_d) begin
      res_o.mode = qdr_pkg::MODE_STARTUP;
    end else if (cfg_i.printing_enable) begin
      res_o.mode = qdr_pkg::MODE_PRINTING;
    end else begin
      res_o.mode = qdr_pkg::MODE_IDLE;
    end
    res_o.left_count   = cnt_out[qdr_pkg::CNT_LEFT];
    res_o.right_count  = cnt_out[qdr_pkg::CNT_RIGHT];
    res_o.error_count  = cnt_out[qdr_pkg::CNT_ERR];
    res_o.bounce_count = cnt_out[qdr_pkg::CNT_BOUNCE];
    res_o.ack_count    = cnt_out[qdr_pkg::CNT_ACK];
  end

  `QDR_ASSERT(a_pulse_implies_limit, (pulse_q != 8'd0) |-> limit_q,
              "pulse counting without limit drive")
  `QDR_ASSERT_ALWAYS(a_drive_needs_phase,
                     (drive_q != 2'd0) |-> (phase_q != qdr_pkg::PHASE_NONE),
                     "winding driven with no phase")
  `QDR_ASSERT(a_serial_on_tick,
              (req_i != qdr_pkg::REQ_TICK) |-> !res_o.serial_request,
              "serial request outside a tick")
  `QDR_ASSERT(a_restart_clears,
              (fire_i && req_i == qdr_pkg::REQ_RESTART) |=>
                (!idle_q && steps_q == 8'd0 &&
                 cnt_q[qdr_pkg::CNT_LEFT] == '0 && cnt_q[qdr_pkg::CNT_ERR] == '0),
              "restart left state behind")

endmodule

`default_nettype wire

// ===== design/quadrature_direction_relay.sv =====
// A request taken into the input register passes through the core into the result register,
//   which drives m_axis.
// Throughput: one request per cycle; the whole update is one pass between the input
//   register and the result register, and both stages advance whenever the result
//   register is empty or the sink takes it.
// Reset (rst_ni low, asynchronous): both stages empty, config back to 50 / 5 / 0,
//   counters, direction, mode, heartbeat and limit pulse cleared, phase set to none.
`default_nettype none

module quadrature_direction_relay #(
  parameter int unsigned COUNT_WIDTH     = 16,
  parameter int unsigned HEARTBEAT_LIMIT = 100
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [3:0] pins, [7:4] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] out_a, [1] out_b, [2] limit_drive, [3] led, [4] serial_request,
  // [6:5] direction, [8:7] mode, [24:9] left_count, [40:25] right_count,
  // [56:41] error_count, [72:57] bounce_count, [88:73] ack_count, [95:89] zero
  output logic [95:0]      m_axis_tdata,
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  qdr_pkg::cfg_t    cfg;
  qdr_pkg::result_t res;

  // Stage 1: registered request
  logic             in_vld_q, in_vld_d;
  qdr_pkg::req_e    in_req_q;
  logic [3:0]       in_pins_q;

  // Stage 2: registered result
  logic             out_vld_q, out_vld_d;
  qdr_pkg::result_t out_res_q;

  logic             advance;   // stage 1 request hits the state this cycle
  logic             in_take;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_req_q  <= qdr_pkg::req_e'(s_axis_tuser);
      in_pins_q <= s_axis_tdata[3:0];
    end
    if (advance) begin
      out_res_q <= res;
    end
  end

  qdr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // decoder state, counters, heartbeat and commutation
  qdr_core #(
    .COUNT_WIDTH     (COUNT_WIDTH),
    .HEARTBEAT_LIMIT (HEARTBEAT_LIMIT)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (in_req_q),
    .pins_i (in_pins_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {
    7'd0,
    out_res_q.ack_count,
    out_res_q.bounce_count,
    out_res_q.error_count,
    out_res_q.right_count,
    out_res_q.left_count,
    out_res_q.mode,
    out_res_q.direction,
    out_res_q.serial_request,
    out_res_q.led,
    out_res_q.limit_drive,
    out_res_q.out_b,
    out_res_q.out_a
  };

endmodule

`default_nettype wire

// ===== tb/relay_tb_pkg.sv =====
package relay_tb_pkg;
  import qdr_pkg::*;

  localparam int unsigned BEAT_LIMIT   = 100;
  localparam int unsigned SERIAL_EVERY = 10;
  localparam int unsigned REPORT_CAP   = 50;

  // one quadrature step from a 2-bit winding phase
  function automatic logic [1:0] quad_cw(logic [1:0] p);
    case (p)
      2'd0: return 2'd1;
      2'd1: return 2'd3;
      2'd2: return 2'd0;
      default: return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] quad_ccw(logic [1:0] p);
    case (p)
      2'd0: return 2'd2;
      2'd1: return 2'd0;
      2'd2: return 2'd3;
      default: return 2'd1;
    endcase
  endfunction

  class relay_scoreboard;
    logic [7:0]  startup_threshold;
    logic [7:0]  limit_pulse_ticks;
    logic        printing_enable;

    logic [3:0]  last_pins;
    dir_e        last_dir;
    logic        running;       // left startup
    logic [7:0]  steps;
    logic [7:0]  pulse_left;
    logic        limit_on;
    logic [6:0]  beat;
    logic        led;
    logic [4:0]  phase;
    logic [1:0]  drive;         // {out_a, out_b}
    logic [15:0] n_left, n_right, n_err, n_bounce, n_ack;

    result_t     status_due[$];
    int unsigned mismatches, compared, startup_exits, led_toggles;

    function new();
      startup_threshold = STARTUP_THRESHOLD_RST;
      limit_pulse_ticks = LIMIT_PULSE_RST;
      printing_enable   = 1'b0;
      last_pins  = '0;
      last_dir   = DIR_UNKNOWN;
      running    = 1'b0;
      steps      = '0;
      pulse_left = '0;
      limit_on   = 1'b0;
      beat       = '0;
      led        = 1'b0;
      phase      = PHASE_NONE;
      drive      = '0;
      n_left = '0; n_right = '0; n_err = '0; n_bounce = '0; n_ack = '0;
      mismatches = 0; compared = 0; startup_exits = 0; led_toggles = 0;
    endfunction

    function void load_reg(cfg_idx_e idx, logic [7:0] value);
      case (idx)
        CFG_STARTUP_THRESHOLD: startup_threshold = value;
        CFG_LIMIT_PULSE_TICKS: limit_pulse_ticks = value;
        CFG_PRINTING_ENABLE:   printing_enable = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return status_due.size();
    endfunction

    // Advance the relay by one request and queue the status word it yields.
    function void apply_event(req_e kind, logic [3:0] pins);
      result_t    st;
      logic       serial;
      logic       changed;
      logic [6:0] prior;
      logic [4:0] ph;
      serial = 1'b0;
      case (kind)
        REQ_TICK: begin
          if (pulse_left != 0) begin
            pulse_left = pulse_left - 1;
          end else begin
            limit_on = 1'b0;
          end
          prior = beat;
          beat  = prior + 7'd1;
          if (prior > BEAT_LIMIT) begin
            beat = '0;
            led  = ~led;
            led_toggles++;
          end
          serial = (beat % SERIAL_EVERY == 0);
        end
        REQ_PIN: begin
          changed = (pins != last_pins);
          if (changed) begin
            if (last_pins <= 4'd3) begin
              if (pins == {2'b00, quad_ccw(last_pins[1:0])}) begin
                last_dir = DIR_LEFT;
              end else if (pins == {2'b00, quad_cw(last_pins[1:0])}) begin
                last_dir = DIR_RIGHT;
              end
            end
            if (last_dir == DIR_UNKNOWN) begin
              n_err++;
            end else begin
              if (last_dir == DIR_RIGHT) begin
                n_right++;
              end else begin
                n_left++;
              end
              if (!running) begin
                steps++;
                if (steps >= startup_threshold) begin
                  running    = 1'b1;
                  limit_on   = 1'b1;
                  pulse_left = limit_pulse_ticks;
                  startup_exits++;
                end
              end
            end
          end else begin
            n_bounce++;
          end
          if (changed && running && printing_enable) begin
            if (phase == PHASE_NONE) begin
              ph = {1'b0, pins};
            end else if (phase <= 5'd3) begin
              ph = {3'b000, quad_cw(phase[1:0])};
            end else begin
              ph = PHASE_NONE;
            end
            drive = ~ph[1:0];
            phase = ph;
          end
          last_pins = pins;
        end
        REQ_ACK: n_ack++;
        default: begin
          steps    = '0;
          running  = 1'b0;
          n_left   = '0;
          n_right  = '0;
          n_err    = '0;
          last_dir = DIR_UNKNOWN;
        end
      endcase
      st.out_a          = drive[1];
      st.out_b          = drive[0];
      st.limit_drive    = limit_on;
      st.led            = led;
      st.serial_request = serial;
      st.direction      = last_dir;
      st.mode           = !running ? MODE_STARTUP :
                          (printing_enable ? MODE_PRINTING : MODE_IDLE);
      st.left_count     = n_left;
      st.right_count    = n_right;
      st.error_count    = n_err;
      st.bounce_count   = n_bounce;
      st.ack_count      = n_ack;
      status_due.push_back(st);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $display("status %0d: %s got 0x%0h expected 0x%0h", compared, what, got, want);
      end
    endtask

    task match_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report(name, got, want);
      end
    endtask

    task take_status(logic [95:0] d);
      result_t want;
      if (status_due.size() == 0) begin
        report("status with none due", d[15:0], 16'd0);
        return;
      end
      want = status_due.pop_front();
      compared++;
      match_field("out_a", d[0], want.out_a);
      match_field("out_b", d[1], want.out_b);
      match_field("limit_drive", d[2], want.limit_drive);
      match_field("led", d[3], want.led);
      match_field("serial_request", d[4], want.serial_request);
      match_field("direction", d[6:5], want.direction);
      match_field("mode", d[8:7], want.mode);
      match_field("left_count", d[24:9], want.left_count);
      match_field("right_count", d[40:25], want.right_count);
      match_field("error_count", d[56:41], want.error_count);
      match_field("bounce_count", d[72:57], want.bounce_count);
      match_field("ack_count", d[88:73], want.ack_count);
      match_field("padding", d[95:89], 16'd0);
    endtask
  endclass

endpackage

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qdr_pkg::*;
  import relay_tb_pkg::*;

  // cycles with no handshake on any channel before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [3:0] pins, [7:4] zero
  logic [1:0]  s_axis_tuser;    // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;    // out_a, out_b, limit, led, serial, dir, mode, counters
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  relay_scoreboard sb = new();

  // stimulus bookkeeping
  logic [3:0]  walk_pins;        // last pin value sent in a pin event
  bit          walk_ccw;         // current walking direction of the encoder
  bit          src_burst;        // sender runs back to back while set
  bit          sink_burst;       // sink starts no new stall while set
  int          restart_odds;     // restarts per thousand random requests
  int unsigned kind_seen[4];
  int unsigned reg_writes, settings_used;
  int unsigned stalled;

  always #2 clk_i = ~clk_i;

  quadrature_direction_relay u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Idle length: mostly short, sometimes medium, rarely a long stretch.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end else if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Next pin value of a well-formed encoder walk; recovers from a noisy value.
  function automatic logic [3:0] next_walk();
    if (walk_pins > 4'd3) begin
      return 4'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 5) == 0) begin
      walk_ccw = !walk_ccw;
    end
    return walk_ccw ? {2'b00, quad_ccw(walk_pins[1:0])} : {2'b00, quad_cw(walk_pins[1:0])};
  endfunction

  // One request on the input stream, with an optional gap in front of it.
  // Entered just after a rising edge; returns at the edge that takes it.
  task automatic send_request(req_e kind, logic [3:0] pins);
    int gap;
    gap = 0;
    if ($urandom_range(0, 59) == 0) begin
      src_burst = !src_burst;
    end
    if (!src_burst && $urandom_range(0, 3) == 0) begin
      gap = idle_len();
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, pins};
    s_axis_tuser  <= kind;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    sb.apply_event(kind, pins);
    if (kind == REQ_PIN) begin
      walk_pins = pins;
    end
    kind_seen[kind]++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.load_reg(idx, value);
    reg_writes++;
  endtask

  // All three registers back to back; printing_enable carries junk above bit 0.
  task automatic apply_settings(logic [7:0] thr, logic [7:0] pulse, bit pe);
    write_reg(CFG_STARTUP_THRESHOLD, thr);
    write_reg(CFG_LIMIT_PULSE_TICKS, pulse);
    write_reg(CFG_PRINTING_ENABLE, {7'($urandom_range(0, 127)), pe});
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Stop sending and let every outstanding status drain out.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_request();
    int         pick;
    logic [3:0] noise;
    pick  = $urandom_range(0, 99);
    noise = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 999) < restart_odds) begin
      send_request(REQ_RESTART, noise);
    end else if (pick < 45) begin
      send_request(REQ_PIN, next_walk());
    end else if (pick < 65) begin
      send_request(REQ_TICK, noise);
    end else if (pick < 73) begin
      send_request(REQ_ACK, noise);
    end else if (pick < 80) begin
      send_request(REQ_PIN, walk_pins);        // bounce
    end else if (pick < 90) begin
      send_request(REQ_PIN, noise);            // arbitrary jump, often not a step
    end else begin
      send_request(REQ_TICK, noise);
    end
  endtask

  // One register setting, then a restart so startup is counted from zero.
  task automatic run_phase(logic [7:0] thr, logic [7:0] pulse, bit pe, int count, int odds);
    drain();
    apply_settings(thr, pulse, pe);
    restart_odds = odds;
    send_request(REQ_RESTART, 4'($urandom_range(0, 15)));
    repeat (count) random_request();
  endtask

  // Sink side: ready drops for random stretches, with calm periods in between.
  initial begin
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) == 0) begin
        sink_burst = !sink_burst;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!sink_burst && $urandom_range(0, 7) == 0) begin
          hold = idle_len();
        end
      end
    end
  end

  // Status check at the rising edge plus a watchdog on all three channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.take_status(m_axis_tdata);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stalled = 0;
      end else if (stalled >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d statuses outstanding",
                 stalled, sb.outstanding());
        $display("Regression FAIL");
        $finish;
      end else begin
        stalled++;
      end
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_TICK;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_STARTUP_THRESHOLD;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    walk_pins     = '0;
    walk_ccw      = 1'b0;
    src_burst     = 1'b0;
    sink_burst    = 1'b0;
    restart_odds  = 0;
    reg_writes    = 0;
    settings_used = 0;
    stalled       = 0;
    kind_seen     = '{default: 0};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset register values ---
    send_request(REQ_TICK, 4'd0);
    send_request(REQ_ACK, 4'd15);
    send_request(REQ_PIN, 4'd0);       // bounce against reset history
    send_request(REQ_PIN, 4'd3);       // jump while direction unknown: error
    send_request(REQ_PIN, 4'd15);      // still unknown, pins above three
    send_request(REQ_PIN, 4'd0);       // no step decoded from a value above three
    send_request(REQ_PIN, 4'd1);       // right
    send_request(REQ_PIN, 4'd3);       // right
    send_request(REQ_PIN, 4'd1);       // left
    send_request(REQ_PIN, 4'd0);       // left
    send_request(REQ_PIN, 4'd2);       // left
    send_request(REQ_PIN, 4'd4);       // invalid jump keeps left
    send_request(REQ_RESTART, 4'd9);
    send_request(REQ_ACK, 4'd6);

    // zero threshold: the first valid step ends startup; longest limit pulse
    drain();
    apply_settings(8'd0, 8'd255, 1'b0);
    send_request(REQ_PIN, 4'd0);       // from above three, unknown: error only
    send_request(REQ_PIN, 4'd2);       // left, leaves startup, limit driven
    send_request(REQ_TICK, 4'd0);
    send_request(REQ_TICK, 4'd0);

    // printing mode: first phase latched from pins above three, then none, then sequence
    drain();
    apply_settings(8'd0, 8'd255, 1'b1);
    send_request(REQ_PIN, 4'd12);
    send_request(REQ_PIN, 4'd0);
    send_request(REQ_PIN, 4'd2);
    send_request(REQ_PIN, 4'd3);
    send_request(REQ_PIN, 4'd3);       // bounce leaves the phase alone
    send_request(REQ_RESTART, 4'd0);
    send_request(REQ_TICK, 4'd0);

    // --- random phases, one per register setting ---
    run_phase(8'd1, 8'd0, 1'b1, 230, 20);
    run_phase(8'd255, 8'd255, 1'b0, 560, 0);
    run_phase(8'($urandom_range(2, 40)), 8'($urandom_range(1, 20)), 1'b1, 230, 3);
    run_phase(8'd50, 8'd5, 1'b0, 230, 5);
    run_phase(8'd0, 8'($urandom_range(0, 255)), 1'b1, 230, 10);
    run_phase(8'($urandom_range(1, 30)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 230, 4);

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      sb.report("statuses never delivered", 16'(sb.outstanding()), 16'd0);
    end

    $display("Covered %0d requests (%0d ticks, %0d pin events, %0d acks, %0d restarts), %0d statuses compared.",
             kind_seen[REQ_TICK] + kind_seen[REQ_PIN] + kind_seen[REQ_ACK] + kind_seen[REQ_RESTART],
             kind_seen[REQ_TICK], kind_seen[REQ_PIN], kind_seen[REQ_ACK], kind_seen[REQ_RESTART],
             sb.compared);
    $display("Startup ended %0d times, LED toggled %0d times, %0d register writes over %0d settings.",
             sb.startup_exits, sb.led_toggles, reg_writes, settings_used);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
